@@ sv/ils_pkg.sv @@
// ----------------------------------------------------------------------------
// ils_pkg
// Shared widths, register indexes and controller/datapath handshake types
// for the integer letterbox scaler.
// ----------------------------------------------------------------------------
package ils_pkg;

  localparam int PIX_W      = 32;
  localparam int ADDR_W     = 24;
  localparam int REG_W      = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int OUT_DATA_W = 56;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 2'd3;

  localparam logic [REG_W-1:0] RST_SRC_WIDTH  = 13'd320;
  localparam logic [REG_W-1:0] RST_SRC_HEIGHT = 13'd200;
  localparam logic [REG_W-1:0] RST_DST_WIDTH  = 13'd640;
  localparam logic [REG_W-1:0] RST_DST_HEIGHT = 13'd400;

  typedef struct packed {
    logic geo_init;
    logic geo_step;
    logic geo_fin;
    logic accept;
    logic mul;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic fit;
    logic in_win;
    logic last_beat;
    logic out_free;
  } dp_sts_t;

endpackage

@@ sv/ils_ctrl.sv @@
// ----------------------------------------------------------------------------
// ils_ctrl
// Sequencer: geometry search after reset or a register write, then per
// pixel an accept, an address multiply and one write per output beat.
// ----------------------------------------------------------------------------
module ils_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ils_pkg::dp_sts_t sts_i,
  output ils_pkg::dp_cmd_t cmd_o
);
  import ils_pkg::*;

  localparam logic [2:0] S_GINIT = 3'd0;
  localparam logic [2:0] S_GSCAN = 3'd1;
  localparam logic [2:0] S_GFIN  = 3'd2;
  localparam logic [2:0] S_IDLE  = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_GINIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_GINIT: begin
        cmd_o.geo_init = 1'b1;
        state_d        = S_GSCAN;
      end
      S_GSCAN: begin
        if (sts_i.fit) begin
          cmd_o.geo_step = 1'b1;
        end else begin
          state_d = S_GFIN;
        end
      end
      S_GFIN: begin
        cmd_o.geo_fin = 1'b1;
        state_d       = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = sts_i.in_win ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.last_beat) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_GINIT;
      end
    endcase
    if (cfg_we_i) begin
      state_d = S_GINIT;
    end
  end

  a_emit_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.out_free)
    else $error("Write issued while the output register was still occupied.");

  a_one_command: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.geo_init, cmd_o.geo_step, cmd_o.geo_fin,
              cmd_o.accept, cmd_o.mul, cmd_o.emit}))
    else $error("More than one datapath command in a cycle.");

  a_accept_to_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.accept && !cfg_we_i) |=> (state_q == S_MUL))
    else $error("Accepted pixel did not proceed to the address multiply.");

  a_cfg_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (state_q == S_GINIT))
    else $error("Register write did not restart the geometry search.");

endmodule

@@ sv/ils_datapath.sv @@
// ----------------------------------------------------------------------------
// ils_datapath
// Configuration registers, geometry search by repeated addition, frame
// position counters, destination address generation and output register.
// ----------------------------------------------------------------------------
module ils_datapath #(
  parameter int MAX_SCALE  = 8,
  parameter int MAX_DIM    = 4096,
  parameter int PIXEL_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ils_pkg::dp_cmd_t               cmd_i,
  output ils_pkg::dp_sts_t               sts_o,
  input  logic                           cfg_we_i,
  input  logic [ils_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ils_pkg::REG_W-1:0]      cfg_data_i,
  input  logic [ils_pkg::PIX_W-1:0]      pixel_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [ils_pkg::ADDR_W-1:0]     out_addr_o,
  output logic [ils_pkg::PIX_W-1:0]      out_pixel_o,
  output logic                           out_last_o
);
  import ils_pkg::*;

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int CNT_W = $clog2(MAX_DIM);
  localparam int SC_W  = $clog2(MAX_SCALE + 1);
  localparam int KW    = $clog2(MAX_SCALE + 2);
  localparam int GA_W  = DIM_W + KW;
  localparam int CL_W  = (REG_W > DIM_W) ? REG_W : DIM_W;
  localparam int PR_W  = 2 * DIM_W;
  localparam int AS_W  = (PR_W > ADDR_W) ? PR_W : ADDR_W;
  localparam int RP_W  = CNT_W + SC_W;
  localparam logic [PIX_W-1:0] PIX_MASK = PIX_W'((64'd1 << PIXEL_BITS) - 64'd1);

  logic [REG_W-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q;
  logic [DIM_W-1:0] sw, sh, dw, dh;

  logic [KW-1:0]    k_q;
  logic [GA_W-1:0]  accw_q, acch_q, pw_q, ph_q;
  logic [SC_W-1:0]  scale_q, seff_q;
  logic [DIM_W-1:0] cl_q, ct_q, ml_q, mt_q, cw_q, ch_q;
  logic [DIM_W-1:0] cl_d, ct_d, ml_d, mt_d, cw_d, ch_d;

  logic [CNT_W-1:0] col_q, row_q;
  logic [DIM_W-1:0] col_inc, row_inc, col_x, row_x, col_off, row_off;
  logic [RP_W-1:0]  ry_prod, cx_prod;
  logic             win;

  logic [PIX_W-1:0] pix_q;
  logic [DIM_W-1:0] dy0_q, dx0_q;
  logic             in_win_q;
  logic [PR_W-1:0]  base_prod;
  logic [AS_W-1:0]  row_base_q, addr_sum;
  logic [SC_W-1:0]  i_q, j_q;
  logic             last_beat;

  logic             out_valid_q, out_last_q;
  logic [ADDR_W-1:0] out_addr_q;
  logic [PIX_W-1:0] out_pixel_q;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [REG_W-1:0] raw);
    logic [CL_W-1:0] ext;
    ext = CL_W'(raw);
    if (ext == '0) begin
      return DIM_W'(1);
    end else if (ext > CL_W'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end
    return ext[DIM_W-1:0];
  endfunction

  assign sw = clamp_dim(src_w_q);
  assign sh = clamp_dim(src_h_q);
  assign dw = clamp_dim(dst_w_q);
  assign dh = clamp_dim(dst_h_q);

  always_comb begin
    if (scale_q == '0) begin
      if (sw >= dw) begin
        cl_d = (sw >> 1) - (dw >> 1);
        ml_d = '0;
        cw_d = dw;
      end else begin
        cl_d = '0;
        ml_d = (dw >> 1) - (sw >> 1);
        cw_d = sw;
      end
      if (sh >= dh) begin
        ct_d = (sh >> 1) - (dh >> 1);
        mt_d = '0;
        ch_d = dh;
      end else begin
        ct_d = '0;
        mt_d = (dh >> 1) - (sh >> 1);
        ch_d = sh;
      end
    end else begin
      cl_d = '0;
      ct_d = '0;
      ml_d = (dw >> 1) - DIM_W'(pw_q >> 1);
      mt_d = (dh >> 1) - DIM_W'(ph_q >> 1);
      cw_d = sw;
      ch_d = sh;
    end
  end

  assign col_x   = DIM_W'(col_q);
  assign row_x   = DIM_W'(row_q);
  assign col_inc = col_x + DIM_W'(1);
  assign row_inc = row_x + DIM_W'(1);
  assign col_off = col_x - cl_q;
  assign row_off = row_x - ct_q;
  assign win     = (col_x >= cl_q) && (col_off < cw_q) &&
                   (row_x >= ct_q) && (row_off < ch_q);
  assign ry_prod = RP_W'(row_q) * RP_W'(seff_q);
  assign cx_prod = RP_W'(col_q) * RP_W'(seff_q);

  assign base_prod = PR_W'(dy0_q) * PR_W'(dw);
  assign addr_sum  = row_base_q + AS_W'(dx0_q) + AS_W'(j_q);
  assign last_beat = (i_q == seff_q - SC_W'(1)) && (j_q == seff_q - SC_W'(1));

  assign sts_o.fit       = (accw_q <= GA_W'(dw)) && (acch_q <= GA_W'(dh)) &&
                           (k_q <= KW'(MAX_SCALE));
  assign sts_o.in_win    = in_win_q;
  assign sts_o.last_beat = last_beat;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q     <= RST_SRC_WIDTH;
      src_h_q     <= RST_SRC_HEIGHT;
      dst_w_q     <= RST_DST_WIDTH;
      dst_h_q     <= RST_DST_HEIGHT;
      k_q         <= '0;
      accw_q      <= '0;
      acch_q      <= '0;
      pw_q        <= '0;
      ph_q        <= '0;
      scale_q     <= '0;
      seff_q      <= SC_W'(1);
      cl_q        <= '0;
      ct_q        <= '0;
      ml_q        <= '0;
      mt_q        <= '0;
      cw_q        <= '0;
      ch_q        <= '0;
      col_q       <= '0;
      row_q       <= '0;
      in_win_q    <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SRC_WIDTH:  src_w_q <= cfg_data_i;
          REG_SRC_HEIGHT: src_h_q <= cfg_data_i;
          REG_DST_WIDTH:  dst_w_q <= cfg_data_i;
          REG_DST_HEIGHT: dst_h_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.geo_init) begin
        k_q     <= KW'(1);
        accw_q  <= GA_W'(sw);
        acch_q  <= GA_W'(sh);
        scale_q <= '0;
        pw_q    <= '0;
        ph_q    <= '0;
        col_q   <= '0;
        row_q   <= '0;
      end
      if (cmd_i.geo_step) begin
        scale_q <= k_q[SC_W-1:0];
        pw_q    <= accw_q;
        ph_q    <= acch_q;
        accw_q  <= accw_q + GA_W'(sw);
        acch_q  <= acch_q + GA_W'(sh);
        k_q     <= k_q + KW'(1);
      end
      if (cmd_i.geo_fin) begin
        cl_q   <= cl_d;
        ct_q   <= ct_d;
        ml_q   <= ml_d;
        mt_q   <= mt_d;
        cw_q   <= cw_d;
        ch_q   <= ch_d;
        seff_q <= (scale_q == '0) ? SC_W'(1) : scale_q;
      end
      if (cmd_i.accept) begin
        in_win_q <= win;
        if (col_inc >= sw) begin
          col_q <= '0;
          row_q <= (row_inc >= sh) ? '0 : row_inc[CNT_W-1:0];
        end else begin
          col_q <= col_inc[CNT_W-1:0];
        end
      end
      if (cmd_i.mul) begin
        i_q <= '0;
        j_q <= '0;
      end
      if (cmd_i.emit) begin
        if (j_q == seff_q - SC_W'(1)) begin
          j_q <= '0;
          i_q <= i_q + SC_W'(1);
        end else begin
          j_q <= j_q + SC_W'(1);
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pix_q <= pixel_i & PIX_MASK;
      dy0_q <= ry_prod[DIM_W-1:0] + mt_q - ct_q;
      dx0_q <= cx_prod[DIM_W-1:0] + ml_q - cl_q;
    end
    if (cmd_i.mul) begin
      row_base_q <= AS_W'(base_prod);
    end else if (cmd_i.emit && (j_q == seff_q - SC_W'(1))) begin
      row_base_q <= row_base_q + AS_W'(dw);
    end
    if (cmd_i.emit) begin
      out_addr_q  <= addr_sum[ADDR_W-1:0];
      out_pixel_q <= pix_q;
      out_last_q  <= last_beat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_addr_o  = out_addr_q;
  assign out_pixel_o = out_pixel_q;
  assign out_last_o  = out_last_q;

  a_scale_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seff_q != '0) && (seff_q <= SC_W'(MAX_SCALE)) && (scale_q <= SC_W'(MAX_SCALE)))
    else $error("Scale factor out of range.");

  a_block_ends_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && last_beat) |=> (i_q == seff_q))
    else $error("Replication block ended before all rows were written.");

endmodule

@@ sv/integer_letterbox_scaler.sv @@
// ----------------------------------------------------------------------------
// integer_letterbox_scaler
// Replicates raster-order source pixels into integer-scaled, centered blocks
// of a destination frame, or center-crops at scale 1 when no scale fits.
//
//   Channel   Dir  Handshake               Payload
//   s_axis    in   tvalid/tready           tdata: pixel_value
//   m_axis    out  tvalid/tready           tdata: dest_address, pixel_out;
//                                          tlast: last_write
//   cfg       in   cfg_we_i (no wait)      cfg_idx_i, cfg_data_i
//
// Each pixel is accepted, then the address multiply runs, then one write per
// beat follows: scale*scale writes, or one write inside the crop window when
// the scale is zero and none when it lies outside; the write sequencer issues
// one address per cycle while the output register is free.
// After reset and after every register write the scale search runs, during
// which s_axis_tready is low.
// A stalled write waits in the output register; the sequencer holds.
// ----------------------------------------------------------------------------
module integer_letterbox_scaler #(
  parameter int MAX_SCALE  = 8,
  parameter int MAX_DIM    = 4096,
  parameter int PIXEL_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [31:0] pixel_value
  input  logic [ils_pkg::PIX_W-1:0]         s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [23:0] dest_address, [55:24] pixel_out
  output logic [ils_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                              m_axis_tlast,
  input  logic                              cfg_we_i,
  input  logic [ils_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ils_pkg::REG_W-1:0]         cfg_data_i
);
  import ils_pkg::*;

  dp_cmd_t           cmd;
  dp_sts_t           sts;
  logic [ADDR_W-1:0] out_addr;
  logic [PIX_W-1:0]  out_pixel;

  ils_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ils_datapath #(
    .MAX_SCALE  (MAX_SCALE),
    .MAX_DIM    (MAX_DIM),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .pixel_i     (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_addr_o  (out_addr),
    .out_pixel_o (out_pixel),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {out_pixel, out_addr};

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for integer_letterbox_scaler. Source pixels are sent
// on the input stream while a local predictor replays the frame walk and
// queues the destination writes each pixel must cause. Every write on the
// output stream is compared with the oldest queued write. Geometry covers
// reset values, saturated scale, scale 1, crop, centering and clamped
// registers, followed by random geometries with random idling on both streams.
// ----------------------------------------------------------------------------
module testbench;
  import ils_pkg::*;

  localparam int          MAX_SCALE   = 8;
  localparam int          MAX_DIM     = 4096;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam logic [3:0]  ALL_REGS    = 4'hF;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  pix;
    logic              last;
  } write_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [PIX_W-1:0]      s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [REG_W-1:0]      cfg_data_i;

  write_t      pending_writes[$];
  write_t      got_write;
  write_t      want_write;
  int unsigned write_errors = 0;
  int unsigned writes_checked = 0;
  int unsigned pixels_sent = 0;
  int unsigned geometry_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_cycles = 0;
  bit          steady = 1'b0;

  logic [REG_W-1:0] reg_sw, reg_sh, reg_dw, reg_dh;
  int unsigned      eff_sw, eff_sh, eff_dw, eff_dh;
  logic [3:0]       fit_scale;
  logic [11:0]      crop_l, crop_t, marg_l, marg_t;
  logic [12:0]      copy_w, copy_h;
  logic [11:0]      pos_col, pos_row;

  integer_letterbox_scaler dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  function automatic int unsigned clamp_dim(input logic [REG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return 32'(v);
  endfunction

  function automatic void fit_axis(input int unsigned s, input int unsigned d,
                                   output logic [11:0] crop, output logic [11:0] margin,
                                   output logic [12:0] copy);
    if (s >= d) begin
      crop   = 12'(s / 2 - d / 2);
      margin = '0;
      copy   = 13'(d);
    end else begin
      crop   = '0;
      margin = 12'(d / 2 - s / 2);
      copy   = 13'(s);
    end
  endfunction

  function automatic void derive_geometry();
    int unsigned ratio;
    eff_sw = clamp_dim(reg_sw);
    eff_sh = clamp_dim(reg_sh);
    eff_dw = clamp_dim(reg_dw);
    eff_dh = clamp_dim(reg_dh);
    ratio = eff_dw / eff_sw;
    if (eff_dh / eff_sh < ratio) ratio = eff_dh / eff_sh;
    if (ratio > MAX_SCALE) ratio = MAX_SCALE;
    fit_scale = 4'(ratio);
    if (ratio == 0) begin
      fit_axis(eff_sw, eff_dw, crop_l, marg_l, copy_w);
      fit_axis(eff_sh, eff_dh, crop_t, marg_t, copy_h);
    end else begin
      crop_l = '0;
      crop_t = '0;
      marg_l = 12'(eff_dw / 2 - (ratio * eff_sw) / 2);
      marg_t = 12'(eff_dh / 2 - (ratio * eff_sh) / 2);
      copy_w = 13'(eff_sw);
      copy_h = 13'(eff_sh);
    end
    pos_col = '0;
    pos_row = '0;
  endfunction

  function automatic void predict_writes(input logic [PIX_W-1:0] px);
    int unsigned col, row, s, dy, dx;
    write_t      w;
    col = 32'(pos_col);
    row = 32'(pos_row);
    s   = 32'(fit_scale);
    w.pix = px;
    if (s == 0) begin
      if (col >= crop_l && col - crop_l < copy_w && row >= crop_t && row - crop_t < copy_h) begin
        dy = row - crop_t + marg_t;
        dx = col - crop_l + marg_l;
        w.addr = ADDR_W'(dy * eff_dw + dx);
        w.last = 1'b1;
        pending_writes.push_back(w);
      end
    end else begin
      for (int i = 0; i < s; i++) begin
        for (int j = 0; j < s; j++) begin
          dy = row * s + i + marg_t;
          dx = col * s + j + marg_l;
          w.addr = ADDR_W'(dy * eff_dw + dx);
          w.last = (i == s - 1) && (j == s - 1);
          pending_writes.push_back(w);
        end
      end
    end
    col++;
    if (col >= eff_sw) begin
      col = 0;
      row++;
      if (row >= eff_sh) row = 0;
    end
    pos_col = 12'(col);
    pos_row = 12'(row);
  endfunction

  function automatic logic [REG_W-1:0] pick_dim(input int unsigned hi);
    if ($urandom_range(0, 11) == 0) begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return REG_W'(MAX_DIM);
        2: return REG_W'($urandom_range(MAX_DIM + 1, 8191));
        default: return REG_W'($urandom_range(1, 8191));
      endcase
    end
    return REG_W'($urandom_range(1, hi));
  endfunction

  function automatic logic [PIX_W-1:0] any_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] px);
    int unsigned gap;
    if (!steady && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_writes(px);
    pixels_sent++;
  endtask

  task automatic drain_writes();
    s_axis_tvalid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
  endtask

  // The pause lets a pixel that causes no write finish before the register moves.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    repeat (16) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_SRC_WIDTH:  reg_sw = val;
      REG_SRC_HEIGHT: reg_sh = val;
      REG_DST_WIDTH:  reg_dw = val;
      REG_DST_HEIGHT: reg_dh = val;
      default: ;
    endcase
    derive_geometry();
  endtask

  task automatic program_geometry(input logic [3:0] mask,
                                  input logic [REG_W-1:0] sw, input logic [REG_W-1:0] sh,
                                  input logic [REG_W-1:0] dw, input logic [REG_W-1:0] dh);
    drain_writes();
    if (mask[REG_SRC_WIDTH])  write_reg(REG_SRC_WIDTH, sw);
    if (mask[REG_SRC_HEIGHT]) write_reg(REG_SRC_HEIGHT, sh);
    if (mask[REG_DST_WIDTH])  write_reg(REG_DST_WIDTH, dw);
    if (mask[REG_DST_HEIGHT]) write_reg(REG_DST_HEIGHT, dh);
    geometry_count++;
  endtask

  task automatic test_reset_geometry();
    send_pixel('0);
    send_pixel('1);
    send_pixel(32'hA5A5_5A5A);
  endtask

  task automatic test_saturated_scale();
    program_geometry(ALL_REGS, 13'd2, 13'd2, 13'd40, 13'd30);
    repeat (5) send_pixel(any_pixel());
  endtask

  task automatic test_register_extremes();
    program_geometry(ALL_REGS, 13'd0, 13'd0, 13'd8191, 13'd8191);
    repeat (2) send_pixel(any_pixel());
    program_geometry(ALL_REGS, 13'd8191, 13'd8191, 13'd1, 13'd1);
    send_pixel(any_pixel());
    program_geometry(ALL_REGS, 13'd4096, 13'd1, 13'd4096, 13'd4097);
    repeat (2) send_pixel(any_pixel());
  endtask

  task automatic test_crop_window();
    program_geometry(ALL_REGS, 13'd3, 13'd2, 13'd1, 13'd1);
    repeat (7) send_pixel(any_pixel());
  endtask

  task automatic test_mixed_axes();
    program_geometry(ALL_REGS, 13'd2, 13'd4, 13'd6, 13'd2);
    repeat (5) send_pixel(any_pixel());
  endtask

  task automatic test_random_geometry();
    int unsigned sent, burst;
    sent = 0;
    while (sent < 370) begin
      program_geometry(4'($urandom_range(1, 15)), pick_dim(8), pick_dim(8),
                       pick_dim(48), pick_dim(48));
      burst = $urandom_range(15, 50);
      repeat (burst) send_pixel(any_pixel());
      sent += burst;
    end
  endtask

  task automatic test_output_backpressure();
    program_geometry(ALL_REGS, 13'd2, 13'd2, 13'd16, 13'd16);
    hold_cycles = 300;
    repeat (12) send_pixel(any_pixel());
  endtask

  task automatic test_sender_pause();
    program_geometry(ALL_REGS, 13'd3, 13'd3, 13'd20, 13'd20);
    repeat (10) send_pixel(any_pixel());
    drain_writes();
    repeat (10) send_pixel(any_pixel());
  endtask

  task automatic test_steady_tail();
    steady = 1'b1;
    program_geometry(ALL_REGS, pick_dim(6), pick_dim(6), pick_dim(32), pick_dim(32));
    repeat (40) send_pixel(any_pixel());
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_SRC_WIDTH;
    cfg_data_i    <= '0;
    reg_sw = RST_SRC_WIDTH;
    reg_sh = RST_SRC_HEIGHT;
    reg_dw = RST_DST_WIDTH;
    reg_dh = RST_DST_HEIGHT;
    derive_geometry();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_geometry();
    test_saturated_scale();
    test_register_extremes();
    test_crop_window();
    test_mixed_axes();
    test_random_geometry();
    test_output_backpressure();
    test_sender_pause();
    test_steady_tail();

    drain_writes();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d source pixels over %0d register settings and checked %0d writes.",
             pixels_sent, geometry_count, writes_checked);
    $display("Scales from crop to saturated, clamped registers, frame wrap and long stalls.");
    if (write_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : sink
    int unsigned stall;
    forever begin
      if (hold_cycles != 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end else if (!steady && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 7);
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_write.addr = m_axis_tdata[ADDR_W-1:0];
      got_write.pix  = m_axis_tdata[ADDR_W +: PIX_W];
      got_write.last = m_axis_tlast;
      if (pending_writes.size() == 0) begin
        write_errors++;
        $display("%0t: unexpected write: expected none, got addr %h pixel %h last %b",
                 $time, got_write.addr, got_write.pix, got_write.last);
      end else begin
        want_write = pending_writes.pop_front();
        writes_checked++;
        if (got_write.addr !== want_write.addr || got_write.pix !== want_write.pix ||
            got_write.last !== want_write.last) begin
          write_errors++;
          $display("%0t: write mismatch: expected addr %h pixel %h last %b, got addr %h pixel %h last %b",
                   $time, want_write.addr, want_write.pix, want_write.last,
                   got_write.addr, got_write.pix, got_write.last);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles, %0d writes outstanding.",
               quiet_cycles, pending_writes.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule
